[hw/rtl/aopf_pkg.sv]
// ----------------------------------------------------------------------------
// aopf_pkg
// Shared types and constants of the AABB overlap pair finder.
// ----------------------------------------------------------------------------
`default_nettype none

package aopf_pkg;

  localparam int unsigned SlotsDef = 8;
  localparam int unsigned IdW      = 31;
  localparam int unsigned PosW     = 16;
  localparam int unsigned HalfW    = 10;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;

  localparam logic [HalfW-1:0] HalfReset = HalfW'(1);

  typedef enum logic [1:0] {
    MODE_ENTER = 2'd0,
    MODE_LEAVE = 2'd1,
    MODE_MOVE  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_DUP       = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_X = 1'b0,
    CFG_HALF_Y = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
  } slot_entry_t;

  typedef struct packed {
    logic           overlap;
    logic           id_eq;
    logic [IdW-1:0] id_lo;
    logic [IdW-1:0] id_hi;
  } cmp_res_t;

endpackage

`default_nettype wire

[hw/rtl/aopf_slot_mem.sv]
// ----------------------------------------------------------------------------
// aopf_slot_mem
// Slot table storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module aopf_slot_mem
  import aopf_pkg::*;
#(
  parameter int unsigned Slots = SlotsDef,
  localparam int unsigned AW   = $clog2(Slots)
) (
  input  wire logic        clk_i,
  input  wire logic        we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire slot_entry_t wdata_i,
  input  wire logic        ren_i,
  input  wire logic [AW-1:0] raddr_a_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output slot_entry_t      rdata_a_o,
  output slot_entry_t      rdata_b_o
);

  slot_entry_t mem_q [Slots];
  slot_entry_t rdata_a_q;
  slot_entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ren_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

[hw/rtl/aopf_cmp_unit.sv]
// ----------------------------------------------------------------------------
// aopf_cmp_unit
// Shared compare unit: id match for lookup, box overlap and id order for scan.
// ----------------------------------------------------------------------------
`default_nettype none

module aopf_cmp_unit
  import aopf_pkg::*;
(
  input  wire slot_entry_t       ent_a_i,
  input  wire slot_entry_t       ent_b_i,
  input  wire logic [IdW-1:0]    key_id_i,
  input  wire logic [HalfW-1:0]  half_x_i,
  input  wire logic [HalfW-1:0]  half_y_i,
  output cmp_res_t               res_o
);

  logic [PosW:0]  dx;
  logic [PosW:0]  dy;
  logic [PosW:0]  adx;
  logic [PosW:0]  ady;
  logic [HalfW:0] lim_x;
  logic [HalfW:0] lim_y;
  logic           a_lt_b;

  always_comb begin
    dx     = {ent_a_i.x[PosW-1], ent_a_i.x} - {ent_b_i.x[PosW-1], ent_b_i.x};
    dy     = {ent_a_i.y[PosW-1], ent_a_i.y} - {ent_b_i.y[PosW-1], ent_b_i.y};
    adx    = dx[PosW] ? (~dx + (PosW+1)'(1)) : dx;
    ady    = dy[PosW] ? (~dy + (PosW+1)'(1)) : dy;
    lim_x  = {half_x_i, 1'b0};
    lim_y  = {half_y_i, 1'b0};
    a_lt_b = ent_a_i.id < ent_b_i.id;

    res_o.overlap = (adx < (PosW+1)'(lim_x)) && (ady < (PosW+1)'(lim_y));
    res_o.id_eq   = ent_a_i.id == key_id_i;
    res_o.id_lo   = a_lt_b ? ent_a_i.id : ent_b_i.id;
    res_o.id_hi   = a_lt_b ? ent_b_i.id : ent_a_i.id;
  end

endmodule

`default_nettype wire

[hw/rtl/aabb_overlap_pair_finder_unit.sv]
// ----------------------------------------------------------------------------
// aabb_overlap_pair_finder_unit
// Slot table of entities with enter/leave/move updates; after each update all
// slot pairs are rescanned and overlapping boxes are reported as words.
// ----------------------------------------------------------------------------
//   channel  | handshake                 | payload
//   in       | in_valid_i / in_stall_o   | mode, entity_id, pos_x, pos_y
//   out      | out_valid_o / out_stall_i | status, has_pair, id_low, id_high, last
//   cfg      | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// An item can be held up while the output register is full and stalled; a move
// of an absent id skips the scan and an unused mode goes straight out.
// The lookup walks one slot per cycle, the scan one slot pair per cycle while no
// pair word waits on a full, stalled output register, both through the two
// read ports of the slot memory and the one compare unit.
// Reset clears all slots and sets both half sizes to 1.
// in_stall_o is high from acceptance until the last word is in the output register.
`default_nettype none

module aabb_overlap_pair_finder_unit
  import aopf_pkg::*;
#(
  parameter int unsigned Slots = SlotsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [IdW-1:0]      entity_id_i,
  input  wire logic signed [PosW-1:0] pos_x_i,
  input  wire logic signed [PosW-1:0] pos_y_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [1:0]          status_o,
  output      logic                has_pair_o,
  output      logic [IdW-1:0]      id_low_o,
  output      logic [IdW-1:0]      id_high_o,
  output      logic                last_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(Slots);
  localparam logic [AW-1:0] LastIdx = AW'(Slots - 1);
  localparam logic [AW-1:0] PenIdx  = AW'(Slots - 2);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SRCH  = 5'b00010,
    ST_UPD   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [HalfW-1:0] half_x_q, half_y_q;
  logic [Slots-1:0] valid_q, valid_d;

  logic [1:0]     mode_q, mode_d;
  logic [IdW-1:0] id_q, id_d;
  logic [PosW-1:0] x_q, x_d, y_q, y_d;
  status_e        status_q, status_d;

  logic [AW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic          iss_done_q, iss_done_d;
  logic          s1_vld_q, s1_vld_d;
  logic [AW-1:0] s1_slot_q, s1_slot_d;
  logic          found_q, found_d;
  logic [AW-1:0] found_slot_q, found_slot_d;

  logic           pend_vld_q, pend_vld_d;
  logic [IdW-1:0] pend_lo_q, pend_lo_d, pend_hi_q, pend_hi_d;

  logic           out_vld_q, out_vld_d;
  status_e        out_status_q;
  logic           out_pair_q, out_last_q;
  logic [IdW-1:0] out_lo_q, out_hi_q;

  logic           push, push_pair, push_last;
  logic [IdW-1:0] push_lo, push_hi;
  logic           can_push, freeze, hit;

  logic          mem_we, mem_ren;
  logic [AW-1:0] mem_waddr;
  slot_entry_t   mem_wdata, rdata_a, rdata_b;
  cmp_res_t      cmp;

  logic          free_any;
  logic [AW-1:0] free_idx;

  aopf_slot_mem #(
    .Slots(Slots)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .ren_i     (mem_ren),
    .raddr_a_i (cnt_a_q),
    .raddr_b_i (cnt_b_q),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  aopf_cmp_unit u_cmp (
    .ent_a_i  (rdata_a),
    .ent_b_i  (rdata_b),
    .key_id_i (id_q),
    .half_x_i (half_x_q),
    .half_y_i (half_y_q),
    .res_o    (cmp)
  );

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  assign can_push  = !out_vld_q || !out_stall_i;
  assign hit       = s1_vld_q && cmp.overlap;
  assign freeze    = (state_q == ST_SCAN) && hit && pend_vld_q && !can_push;
  assign mem_wdata = '{id: id_q, x: x_q, y: y_q};

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    mode_d       = mode_q;
    id_d         = id_q;
    x_d          = x_q;
    y_d          = y_q;
    status_d     = status_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    iss_done_d   = iss_done_q;
    s1_vld_d     = 1'b0;
    s1_slot_d    = s1_slot_q;
    found_d      = found_q;
    found_slot_d = found_slot_q;
    pend_vld_d   = pend_vld_q;
    pend_lo_d    = pend_lo_q;
    pend_hi_d    = pend_hi_q;
    mem_we       = 1'b0;
    mem_waddr    = found_slot_q;
    mem_ren      = 1'b0;
    push         = 1'b0;
    push_pair    = 1'b0;
    push_last    = 1'b0;
    push_lo      = '0;
    push_hi      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d     = mode_i;
          id_d       = entity_id_i;
          x_d        = pos_x_i;
          y_d        = pos_y_i;
          status_d   = STAT_OK;
          cnt_a_d    = '0;
          iss_done_d = 1'b0;
          found_d    = 1'b0;
          pend_vld_d = 1'b0;
          if (mode_i inside {MODE_ENTER, MODE_LEAVE, MODE_MOVE}) begin
            state_d = ST_SRCH;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_SRCH: begin
        if (!iss_done_q) begin
          mem_ren   = 1'b1;
          s1_vld_d  = valid_q[cnt_a_q];
          s1_slot_d = cnt_a_q;
          if (cnt_a_q == LastIdx) begin
            iss_done_d = 1'b1;
          end else begin
            cnt_a_d = cnt_a_q + AW'(1);
          end
        end
        if (s1_vld_q && cmp.id_eq && !found_q) begin
          found_d      = 1'b1;
          found_slot_d = s1_slot_q;
        end
        if (iss_done_q) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cnt_a_d    = '0;
        cnt_b_d    = AW'(1);
        iss_done_d = 1'b0;
        state_d    = ST_SCAN;
        case (mode_q)
          MODE_ENTER: begin
            if (found_q) begin
              status_d = STAT_DUP;
            end else if (free_any) begin
              mem_we            = 1'b1;
              mem_waddr         = free_idx;
              valid_d[free_idx] = 1'b1;
            end else begin
              status_d = STAT_FULL;
            end
          end
          MODE_LEAVE: begin
            if (found_q) begin
              valid_d[found_slot_q] = 1'b0;
            end else begin
              status_d = STAT_NOT_FOUND;
            end
          end
          MODE_MOVE: begin
            if (found_q) begin
              mem_we = 1'b1;
            end else begin
              status_d = STAT_NOT_FOUND;
              state_d  = ST_FLUSH;
            end
          end
          default: begin
            state_d = ST_FLUSH;
          end
        endcase
      end
      ST_SCAN: begin
        if (freeze) begin
          s1_vld_d = s1_vld_q;
        end else begin
          if (!iss_done_q) begin
            mem_ren  = 1'b1;
            s1_vld_d = valid_q[cnt_a_q] && valid_q[cnt_b_q];
            if (cnt_b_q == LastIdx) begin
              if (cnt_a_q == PenIdx) begin
                iss_done_d = 1'b1;
              end else begin
                cnt_a_d = cnt_a_q + AW'(1);
                cnt_b_d = cnt_a_q + AW'(2);
              end
            end else begin
              cnt_b_d = cnt_b_q + AW'(1);
            end
          end
          if (hit) begin
            if (pend_vld_q) begin
              push      = 1'b1;
              push_pair = 1'b1;
              push_lo   = pend_lo_q;
              push_hi   = pend_hi_q;
            end
            pend_vld_d = 1'b1;
            pend_lo_d  = cmp.id_lo;
            pend_hi_d  = cmp.id_hi;
          end
          if (iss_done_q) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          push      = 1'b1;
          push_last = 1'b1;
          push_pair = pend_vld_q;
          push_lo   = pend_vld_q ? pend_lo_q : '0;
          push_hi   = pend_vld_q ? pend_hi_q : '0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (push) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      half_x_q   <= HalfReset;
      half_y_q   <= HalfReset;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      iss_done_q <= 1'b0;
      s1_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      iss_done_q <= iss_done_d;
      s1_vld_q   <= s1_vld_d;
      found_q    <= found_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_HALF_X: half_x_q <= cfg_wdata_i;
          CFG_HALF_Y: half_y_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    id_q         <= id_d;
    x_q          <= x_d;
    y_q          <= y_d;
    status_q     <= status_d;
    s1_slot_q    <= s1_slot_d;
    found_slot_q <= found_slot_d;
    pend_lo_q    <= pend_lo_d;
    pend_hi_q    <= pend_hi_d;
    if (push) begin
      out_status_q <= status_q;
      out_pair_q   <= push_pair;
      out_lo_q     <= push_lo;
      out_hi_q     <= push_hi;
      out_last_q   <= push_last;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_vld_q;
  assign status_o    = out_status_q;
  assign has_pair_o  = out_pair_q;
  assign id_low_o    = out_lo_q;
  assign id_high_o   = out_hi_q;
  assign last_o      = out_last_q;

  // a word without a pair always closes its item
  a_nopair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_pair_o |-> last_o)
    else $error("pairless word not marked last");

  // a successful enter occupies exactly one more slot
  a_enter_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) && (mode_q == MODE_ENTER) && !found_q && free_any |=>
    $countones(valid_q) == $countones($past(valid_q)) + 1)
    else $error("enter did not take one slot");

  // lookup hit must point at an occupied slot
  a_found_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) && found_q |-> valid_q[found_slot_q])
    else $error("lookup hit on free slot");

  a_pend_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> pend_lo_q <= pend_hi_q)
    else $error("pending pair out of order");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !s1_vld_q)
    else $error("compare stage busy while idle");

endmodule

`default_nettype wire

[bench/aabb_overlap_pair_finder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_overlap_pair_finder_checker
// Watches the update, result and register channels of the overlap pair finder,
// keeps its own slot table and box half sizes, predicts the pair words of every
// accepted update and compares each accepted result word field by field.
// ----------------------------------------------------------------------------

module aabb_overlap_pair_finder_checker
  import aopf_pkg::*;
#(
  parameter int unsigned Slots = SlotsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [1:0]                 mode_i,
  input  logic [IdW-1:0]             entity_id_i,
  input  logic signed [PosW-1:0]     pos_x_i,
  input  logic signed [PosW-1:0]     pos_y_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [1:0]                 status_i,
  input  logic                       has_pair_i,
  input  logic [IdW-1:0]             id_low_i,
  input  logic [IdW-1:0]             id_high_i,
  input  logic                       last_i,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  output int                         pending_o,
  output int                         fail_count_o
);

  typedef struct {
    status_e        status;
    logic           has_pair;
    logic [IdW-1:0] id_low;
    logic [IdW-1:0] id_high;
    logic           last;
  } pair_word_t;

  pair_word_t              pair_word_q[$];
  logic                    occupied [Slots];
  logic [IdW-1:0]          ent_id   [Slots];
  logic signed [PosW-1:0]  ent_x    [Slots];
  logic signed [PosW-1:0]  ent_y    [Slots];
  logic [HalfW-1:0]        half_x;
  logic [HalfW-1:0]        half_y;

  function automatic int abs_diff(input logic signed [PosW-1:0] a,
                                  input logic signed [PosW-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  // Apply one update to the slot table and queue the words it produces.
  function automatic void predict_update(input logic [1:0] mode,
                                         input logic [IdW-1:0] id,
                                         input logic signed [PosW-1:0] x,
                                         input logic signed [PosW-1:0] y);
    int         i;
    int         j;
    int         found;
    int         free_slot;
    int         count;
    int         lim_x;
    int         lim_y;
    bit         do_scan;
    status_e    st;
    pair_word_t word;
    found   = -1;
    st      = STAT_OK;
    do_scan = 1'b1;
    for (i = 0; i < Slots; i++) begin
      if (found < 0 && occupied[i] && ent_id[i] == id) found = i;
    end
    case (mode)
      MODE_ENTER: begin
        if (found >= 0) begin
          st = STAT_DUP;
        end else begin
          st        = STAT_FULL;
          free_slot = -1;
          for (i = 0; i < Slots; i++) begin
            if (free_slot < 0 && !occupied[i]) free_slot = i;
          end
          if (free_slot >= 0) begin
            occupied[free_slot] = 1'b1;
            ent_id[free_slot]   = id;
            ent_x[free_slot]    = x;
            ent_y[free_slot]    = y;
            st                  = STAT_OK;
          end
        end
      end
      MODE_LEAVE: begin
        if (found >= 0) occupied[found] = 1'b0;
        else st = STAT_NOT_FOUND;
      end
      MODE_MOVE: begin
        if (found >= 0) begin
          ent_x[found] = x;
          ent_y[found] = y;
        end else begin
          st      = STAT_NOT_FOUND;
          do_scan = 1'b0;
        end
      end
      default: begin
        do_scan = 1'b0;
      end
    endcase
    count = 0;
    lim_x = 2 * int'(half_x);
    lim_y = 2 * int'(half_y);
    if (do_scan) begin
      for (i = 0; i < Slots; i++) begin
        for (j = i + 1; j < Slots; j++) begin
          if (occupied[i] && occupied[j] &&
              abs_diff(ent_x[i], ent_x[j]) < lim_x &&
              abs_diff(ent_y[i], ent_y[j]) < lim_y) begin
            word.status   = st;
            word.has_pair = 1'b1;
            word.id_low   = (ent_id[i] < ent_id[j]) ? ent_id[i] : ent_id[j];
            word.id_high  = (ent_id[i] < ent_id[j]) ? ent_id[j] : ent_id[i];
            word.last     = 1'b0;
            pair_word_q.push_back(word);
            count++;
          end
        end
      end
    end
    if (count == 0) begin
      word.status   = st;
      word.has_pair = 1'b0;
      word.id_low   = '0;
      word.id_high  = '0;
      word.last     = 1'b1;
      pair_word_q.push_back(word);
    end else begin
      pair_word_q[pair_word_q.size()-1].last = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    pair_word_t exp_word;
    int         i;
    if (!rst_ni) begin
      for (i = 0; i < Slots; i++) occupied[i] = 1'b0;
      half_x = HalfReset;
      half_y = HalfReset;
      pair_word_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HALF_X) half_x = cfg_wdata_i;
        else if (cfg_idx_i == CFG_HALF_Y) half_y = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_update(mode_i, entity_id_i, pos_x_i, pos_y_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pair_word_q.size() == 0) begin
          $error("unexpected word: status %0d has_pair %0d id_low %0h id_high %0h last %0d",
                 status_i, has_pair_i, id_low_i, id_high_i, last_i);
          fail_count_o++;
        end else begin
          exp_word = pair_word_q.pop_front();
          if (status_i !== exp_word.status) begin
            $error("status: expected %0d, actual %0d", exp_word.status, status_i);
            fail_count_o++;
          end
          if (has_pair_i !== exp_word.has_pair) begin
            $error("has_pair: expected %0d, actual %0d", exp_word.has_pair, has_pair_i);
            fail_count_o++;
          end
          if (id_low_i !== exp_word.id_low) begin
            $error("id_low: expected %0h, actual %0h", exp_word.id_low, id_low_i);
            fail_count_o++;
          end
          if (id_high_i !== exp_word.id_high) begin
            $error("id_high: expected %0h, actual %0h", exp_word.id_high, id_high_i);
            fail_count_o++;
          end
          if (last_i !== exp_word.last) begin
            $error("last: expected %0d, actual %0d", exp_word.last, last_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o <= pair_word_q.size();
  end

endmodule

[bench/tb_aabb_overlap_pair_finder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aabb_overlap_pair_finder_unit
// Drives enter/leave/move and spare-mode updates and half size settings into the overlap pair
// finder: a directed pass over table corners, then clustered random updates
// under several box sizes and stall mixes. The checker does the comparing.
// ----------------------------------------------------------------------------

module tb_aabb_overlap_pair_finder_unit;
  import aopf_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int IdPool     = 12;
  localparam int PhaseItems = 75;
  localparam int Phases     = 6;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             mode_i      = MODE_ENTER;
  logic [IdW-1:0]         entity_id_i = '0;
  logic signed [PosW-1:0] pos_x_i     = '0;
  logic signed [PosW-1:0] pos_y_i     = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [1:0]             status_o;
  logic                   has_pair_o;
  logic [IdW-1:0]         id_low_o;
  logic [IdW-1:0]         id_high_o;
  logic                   last_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i   = CFG_HALF_X;
  logic [CfgDataW-1:0]    cfg_wdata_i = '0;

  int pending_words;
  int fail_count;
  int send_idle_pct = 13;
  int recv_idle_pct = 79;

  logic [IdW-1:0]   id_pool  [IdPool];
  logic [HalfW-1:0] phase_hx [Phases] = '{10'd2, 10'd0, 10'd1023, 10'd40, 10'd1, 10'd1023};
  logic [HalfW-1:0] phase_hy [Phases] = '{10'd3, 10'd9, 10'd1023, 10'd1, 10'd1, 10'd0};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  aabb_overlap_pair_finder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .entity_id_i (entity_id_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .has_pair_o  (has_pair_o),
    .id_low_o    (id_low_o),
    .id_high_o   (id_high_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  aabb_overlap_pair_finder_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .mode_i       (mode_i),
    .entity_id_i  (entity_id_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .has_pair_i   (has_pair_o),
    .id_low_i     (id_low_o),
    .id_high_i    (id_high_o),
    .last_i       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending_words),
    .fail_count_o (fail_count)
  );

  initial begin
    #12_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic signed [PosW-1:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return PosW'(v);
  endfunction

  task automatic send_update(input logic [1:0] mode, input logic [IdW-1:0] id,
                             input logic signed [PosW-1:0] x,
                             input logic signed [PosW-1:0] y);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    entity_id_i <= id;
    pos_x_i     <= x;
    pos_y_i     <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  task automatic write_halves(input logic [HalfW-1:0] hx, input logic [HalfW-1:0] hy);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HALF_X;
    cfg_wdata_i <= hx;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HALF_Y;
    cfg_wdata_i <= hy;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed updates on a small id pool around one cluster center,
  // so the table fills up and boxes overlap; the rest is raw noise.
  task automatic send_random_update(input int hx, input int hy, input int cx, input int cy);
    int             r;
    int             px;
    int             py;
    logic [1:0]     mode;
    logic [IdW-1:0] id;
    r = $urandom_range(99);
    if (r < 15) begin
      mode = 2'($urandom_range(3));
      id   = IdW'($urandom);
      px   = int'($urandom_range(65535)) - 32768;
      py   = int'($urandom_range(65535)) - 32768;
    end else begin
      r    = $urandom_range(99);
      mode = (r < 40) ? MODE_ENTER : (r < 65) ? MODE_LEAVE : MODE_MOVE;
      id   = id_pool[$urandom_range(IdPool-1)];
      if ($urandom_range(9) == 0) begin
        px = int'($urandom_range(65535)) - 32768;
        py = int'($urandom_range(65535)) - 32768;
      end else begin
        px = cx + int'($urandom_range(4*hx + 4)) - (2*hx + 2);
        py = cy + int'($urandom_range(4*hy + 4)) - (2*hy + 2);
      end
    end
    send_update(mode, id, clamp16(px), clamp16(py));
  endtask

  initial begin
    int k;
    int sp;
    int cx;
    int cy;
    for (k = 0; k < IdPool; k++) id_pool[k] = IdW'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, absent ids, spare mode
    send_update(MODE_MOVE, 31'd7, 16'sd1, 16'sd1);
    send_update(MODE_LEAVE, 31'd7, 16'sd0, 16'sd0);
    send_update(MODE_SPARE, 31'h7fff_ffff, -16'sd1, -16'sd1);
    // corner positions, duplicate id, fill to full
    send_update(MODE_ENTER, 31'd0, 16'sh8000, 16'sh8000);
    send_update(MODE_ENTER, 31'h7fff_ffff, 16'sh8001, 16'sh8000);
    send_update(MODE_ENTER, 31'd0, 16'sd5, 16'sd5);
    for (k = 0; k < 6; k++) send_update(MODE_ENTER, IdW'(100 + k), 16'sh7fff, 16'sh7fff);
    send_update(MODE_ENTER, 31'd200, 16'sd0, 16'sd0);
    send_update(MODE_MOVE, 31'd100, 16'sh8000, 16'sh8001);
    send_update(MODE_LEAVE, 31'h7fff_ffff, 16'sd0, 16'sd0);
    send_update(MODE_ENTER, 31'd3, 16'sd0, 16'sd0);
    send_update(MODE_LEAVE, 31'd0, 16'sd0, 16'sd0);
    // zero half sizes
    wait_for_results();
    write_halves(10'd0, 10'd1023);
    send_update(MODE_MOVE, 31'd3, 16'sd0, 16'sd0);
    wait_for_results();
    write_halves(10'd1023, 10'd0);
    send_update(MODE_MOVE, 31'd101, 16'sh7fff, 16'sh7fff);
    // largest boxes
    wait_for_results();
    write_halves(10'd1023, 10'd1023);
    send_update(MODE_MOVE, 31'd3, 16'sd32000, 16'sd32000);
    send_update(MODE_ENTER, 31'd300, 16'sh8000, 16'sh7fff);
    send_update(MODE_ENTER, 31'd400, 16'sd0, 16'sd0);

    for (sp = 0; sp < Phases; sp++) begin
      wait_for_results();
      write_halves(phase_hx[sp], phase_hy[sp]);
      send_idle_pct = (sp < 2) ? 13 : (sp < 4) ? 79 : 0;
      recv_idle_pct = (sp < 2) ? 79 : (sp < 4) ? 13 : 0;
      cx = int'($urandom_range(65535)) - 32768;
      cy = int'($urandom_range(65535)) - 32768;
      for (k = 0; k < PhaseItems; k++) begin
        if (sp == 1 && k == PhaseItems / 2) wait_for_results();
        send_random_update(int'(phase_hx[sp]), int'(phase_hy[sp]), cx, cy);
      end
    end

    wait_for_results();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
